// File: rtl/zcet_pkg.sv
package zcet_pkg;

  localparam int MAG_W      = 16;
  localparam int FIELD_W    = 20;
  localparam int RATE_W     = 24;
  localparam int MS_W       = 22;
  localparam int VOL_W      = 16;
  localparam int ED_W       = 60;
  localparam int TQ_W       = 37;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_X = 3'd0,
    REG_FIELD_Y = 3'd1,
    REG_FIELD_Z = 3'd2,
    REG_RATE_X  = 3'd3,
    REG_RATE_Y  = 3'd4,
    REG_RATE_Z  = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SCALE,
    ST_EPROD,
    ST_EACC,
    ST_RMUL,
    ST_RCOMB,
    ST_RADD1,
    ST_RADD2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic prod;
    logic sum;
    logic scale;
    logic eprod;
    logic eacc;
    logic rmul;
    logic rcomb;
    logic radd1;
    logic radd2;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  // Saturating signed 64-bit add.
  function automatic logic signed [ACC_W-1:0] sat_add64(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? S64_MIN : S64_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  // Clamp an 88-bit signed value to the signed 64-bit range.
  function automatic logic signed [ACC_W-1:0] sat_to64(input logic signed [87:0] v);
    if ((&v[87:ACC_W-1]) || !(|v[87:ACC_W-1])) begin
      return v[ACC_W-1:0];
    end
    return v[87] ? S64_MIN : S64_MAX;
  endfunction

endpackage

// File: rtl/zcet_in_if.sv
interface zcet_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [zcet_pkg::MAG_W-1:0]    mag_x;
  logic signed [zcet_pkg::MAG_W-1:0]    mag_y;
  logic signed [zcet_pkg::MAG_W-1:0]    mag_z;
  logic        [zcet_pkg::MS_W-1:0]     sat_mag;
  logic        [zcet_pkg::VOL_W-1:0]    volume;
  logic                                 last_cell;

  modport source (
    output valid, mag_x, mag_y, mag_z, sat_mag, volume, last_cell,
    input  ready
  );
  modport sink (
    input  valid, mag_x, mag_y, mag_z, sat_mag, volume, last_cell,
    output ready
  );
endinterface

// File: rtl/zcet_out_if.sv
interface zcet_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [zcet_pkg::ED_W-1:0]     energy_density;
  logic signed [zcet_pkg::TQ_W-1:0]     torque_x;
  logic signed [zcet_pkg::TQ_W-1:0]     torque_y;
  logic signed [zcet_pkg::TQ_W-1:0]     torque_z;
  logic signed [zcet_pkg::ACC_W-1:0]    energy_total;
  logic signed [zcet_pkg::ACC_W-1:0]    energy_rate;
  logic                                 is_last;

  modport source (
    output valid, energy_density, torque_x, torque_y, torque_z,
           energy_total, energy_rate, is_last,
    input  ready
  );
  modport sink (
    input  valid, energy_density, torque_x, torque_y, torque_z,
           energy_total, energy_rate, is_last,
    output ready
  );
endinterface

// File: rtl/zcet_ctrl.sv
module zcet_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_ready,
  input  zcet_pkg::status_t  status,
  output logic               in_ready,
  output logic               out_valid,
  output zcet_pkg::cmd_t     cmd
);
  import zcet_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register valid: set on emit, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MUL;
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_EPROD;
      ST_EPROD: state_next = ST_EACC;
      ST_EACC:  state_next = status.last ? ST_RMUL : ST_DONE;
      ST_RMUL:  state_next = ST_RCOMB;
      ST_RCOMB: state_next = ST_RADD1;
      ST_RADD1: state_next = ST_RADD2;
      ST_RADD2: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_MUL:   cmd.prod  = 1'b1;
      ST_SUM:   cmd.sum   = 1'b1;
      ST_SCALE: cmd.scale = 1'b1;
      ST_EPROD: cmd.eprod = 1'b1;
      ST_EACC:  cmd.eacc  = 1'b1;
      ST_RMUL:  cmd.rmul  = 1'b1;
      ST_RCOMB: cmd.rcomb = 1'b1;
      ST_RADD1: cmd.radd1 = 1'b1;
      ST_RADD2: cmd.radd2 = 1'b1;
      ST_DONE:  cmd.emit  = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/zcet_datapath.sv
module zcet_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic        [zcet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [zcet_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [zcet_pkg::MAG_W-1:0]      mag_x,
  input  logic signed [zcet_pkg::MAG_W-1:0]      mag_y,
  input  logic signed [zcet_pkg::MAG_W-1:0]      mag_z,
  input  logic        [zcet_pkg::MS_W-1:0]       sat_mag,
  input  logic        [zcet_pkg::VOL_W-1:0]      volume,
  input  logic                                   last_cell,
  input  zcet_pkg::cmd_t                         cmd,
  output zcet_pkg::status_t                      status,
  output logic signed [zcet_pkg::ED_W-1:0]       energy_density,
  output logic signed [zcet_pkg::TQ_W-1:0]       torque_x,
  output logic signed [zcet_pkg::TQ_W-1:0]       torque_y,
  output logic signed [zcet_pkg::TQ_W-1:0]       torque_z,
  output logic signed [zcet_pkg::ACC_W-1:0]      energy_total,
  output logic signed [zcet_pkg::ACC_W-1:0]      energy_rate,
  output logic                                   is_last
);
  import zcet_pkg::*;

  localparam int PROD_W  = MAG_W + FIELD_W;       // m times H
  localparam int DOT_W   = PROD_W + 2;
  localparam int SCALE_W = MS_W + VOL_W;          // Ms times volume
  localparam int MT_W    = 54;                    // moment term
  localparam int MSD_W   = DOT_W + MS_W + 1;
  localparam int EP_W    = ED_W + VOL_W + 1;
  localparam int LO_W    = 33 + RATE_W;
  localparam int HI_W    = 32 + RATE_W;

  // Configuration
  logic signed [FIELD_W-1:0] hx, hy, hz;
  logic signed [RATE_W-1:0]  rx, ry, rz;

  // Captured cell
  logic signed [MAG_W-1:0]   mx, my, mz;
  logic        [MS_W-1:0]    ms;
  logic        [VOL_W-1:0]   vol;
  logic                      last;

  logic signed [PROD_W-1:0]  pd_x, pd_y, pd_z;
  logic signed [PROD_W-1:0]  c_yz, c_zy, c_zx, c_xz, c_xy, c_yx;
  logic        [SCALE_W-1:0] scale;
  logic signed [DOT_W-1:0]   dot;
  logic signed [TQ_W-1:0]    tq_x, tq_y, tq_z;
  logic signed [MT_W-1:0]    mt_x, mt_y, mt_z;
  logic signed [ED_W-1:0]    ed;
  logic signed [EP_W-1:0]    eprod;
  logic signed [MSD_W-1:0]   ms_dot;

  logic signed [ACC_W-1:0]   energy_acc, acc_x, acc_y, acc_z;

  logic signed [LO_W-1:0]    lo_x, lo_y, lo_z;
  logic signed [HI_W-1:0]    hi_x, hi_y, hi_z;
  logic signed [ACC_W-1:0]   pr_x, pr_y, pr_z;
  logic signed [ACC_W-1:0]   rsum, rsum_fin, rate_val;

  assign status.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hx <= '0;
      hy <= '0;
      hz <= '0;
      rx <= '0;
      ry <= '0;
      rz <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIELD_X: hx <= cfg_data[FIELD_W-1:0];
        REG_FIELD_Y: hy <= cfg_data[FIELD_W-1:0];
        REG_FIELD_Z: hz <= cfg_data[FIELD_W-1:0];
        REG_RATE_X:  rx <= cfg_data[RATE_W-1:0];
        REG_RATE_Y:  ry <= cfg_data[RATE_W-1:0];
        REG_RATE_Z:  rz <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign ms_dot   = MSD_W'($signed({1'b0, ms})) * MSD_W'(dot);
  assign rsum_fin = sat_add64(rsum, pr_z);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mx   <= mag_x;
      my   <= mag_y;
      mz   <= mag_z;
      ms   <= sat_mag;
      vol  <= volume;
      last <= last_cell;
    end
    if (cmd.prod) begin
      pd_x  <= PROD_W'(mx) * PROD_W'(hx);
      pd_y  <= PROD_W'(my) * PROD_W'(hy);
      pd_z  <= PROD_W'(mz) * PROD_W'(hz);
      c_yz  <= PROD_W'(my) * PROD_W'(hz);
      c_zy  <= PROD_W'(mz) * PROD_W'(hy);
      c_zx  <= PROD_W'(mz) * PROD_W'(hx);
      c_xz  <= PROD_W'(mx) * PROD_W'(hz);
      c_xy  <= PROD_W'(mx) * PROD_W'(hy);
      c_yx  <= PROD_W'(my) * PROD_W'(hx);
      scale <= SCALE_W'(ms) * SCALE_W'(vol);
    end
    if (cmd.sum) begin
      dot  <= DOT_W'(pd_x) + DOT_W'(pd_y) + DOT_W'(pd_z);
      tq_x <= TQ_W'(c_yz) - TQ_W'(c_zy);
      tq_y <= TQ_W'(c_zx) - TQ_W'(c_xz);
      tq_z <= TQ_W'(c_xy) - TQ_W'(c_yx);
      mt_x <= MT_W'($signed({1'b0, scale})) * MT_W'(mx);
      mt_y <= MT_W'($signed({1'b0, scale})) * MT_W'(my);
      mt_z <= MT_W'($signed({1'b0, scale})) * MT_W'(mz);
    end
    if (cmd.scale) begin
      ed <= ED_W'(-ms_dot);
    end
    if (cmd.eprod) begin
      eprod <= EP_W'(ed) * EP_W'($signed({1'b0, vol}));
    end
    // Form each 64 x 24 product from the low and high 32-bit halves of the accumulator.
    if (cmd.rmul) begin
      lo_x <= LO_W'($signed({1'b0, acc_x[31:0]})) * LO_W'(rx);
      lo_y <= LO_W'($signed({1'b0, acc_y[31:0]})) * LO_W'(ry);
      lo_z <= LO_W'($signed({1'b0, acc_z[31:0]})) * LO_W'(rz);
      hi_x <= HI_W'($signed(acc_x[63:32])) * HI_W'(rx);
      hi_y <= HI_W'($signed(acc_y[63:32])) * HI_W'(ry);
      hi_z <= HI_W'($signed(acc_z[63:32])) * HI_W'(rz);
    end
    if (cmd.rcomb) begin
      pr_x <= sat_to64((88'(hi_x) <<< 32) + 88'(lo_x));
      pr_y <= sat_to64((88'(hi_y) <<< 32) + 88'(lo_y));
      pr_z <= sat_to64((88'(hi_z) <<< 32) + 88'(lo_z));
    end
    if (cmd.radd1) begin
      rsum <= sat_add64(pr_x, pr_y);
    end
    if (cmd.radd2) begin
      rate_val <= (rsum_fin == S64_MIN) ? S64_MAX : -rsum_fin;
    end
    if (cmd.emit) begin
      energy_density <= ed;
      torque_x       <= tq_x;
      torque_y       <= tq_y;
      torque_z       <= tq_z;
      energy_total   <= last ? energy_acc : '0;
      energy_rate    <= last ? rate_val : '0;
      is_last        <= last;
    end
  end

  // Running sums; clear once the last cell's totals are out.
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_acc <= '0;
      acc_x      <= '0;
      acc_y      <= '0;
      acc_z      <= '0;
    end else if (cmd.emit && last) begin
      energy_acc <= '0;
      acc_x      <= '0;
      acc_y      <= '0;
      acc_z      <= '0;
    end else begin
      if (cmd.scale) begin
        acc_x <= sat_add64(acc_x, ACC_W'(mt_x));
        acc_y <= sat_add64(acc_y, ACC_W'(mt_y));
        acc_z <= sat_add64(acc_z, ACC_W'(mt_z));
      end
      if (cmd.eacc) begin
        energy_acc <= sat_add64(energy_acc, sat_to64(88'(eprod)));
      end
    end
  end

endmodule

// File: rtl/zeeman_cell_energy_torque_unit.sv
// Channel   Dir  Payload                                              Transfer
// cell_in   in   mag_x/y/z, sat_mag, volume, last_cell                valid & ready
// cell_out  out  energy_density, torque_x/y/z, energy_total,          valid & ready
//                energy_rate, is_last
// cfg       in   cfg_index, cfg_data                                  cfg_we
//
// One cell at a time: the next input transfer waits until the controller's step
// sequence for the current cell is through (products, sums, scaling, energy product,
// energy accumulate, then four rate steps for a cell with last_cell set).
// Reset clears the field and rate registers, the running sums and the control.
// A result waiting in the output register does not hold off the next cell; only
// the step that loads a new result waits for the output register to free up.
module zeeman_cell_energy_torque_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  zcet_in_if.sink                                cell_in,
  zcet_out_if.source                             cell_out,
  input  logic                                   cfg_we,
  input  logic        [zcet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [zcet_pkg::CFG_DATA_W-1:0] cfg_data
);
  import zcet_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence the steps for each cell and own the output handshake.
  zcet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cell_in.valid),
    .out_ready (cell_out.ready),
    .status    (status),
    .in_ready  (cell_in.ready),
    .out_valid (cell_out.valid),
    .cmd       (cmd)
  );

  // Hold configuration, products, running sums and the output register.
  zcet_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mag_x          (cell_in.mag_x),
    .mag_y          (cell_in.mag_y),
    .mag_z          (cell_in.mag_z),
    .sat_mag        (cell_in.sat_mag),
    .volume         (cell_in.volume),
    .last_cell      (cell_in.last_cell),
    .cmd            (cmd),
    .status         (status),
    .energy_density (cell_out.energy_density),
    .torque_x       (cell_out.torque_x),
    .torque_y       (cell_out.torque_y),
    .torque_z       (cell_out.torque_z),
    .energy_total   (cell_out.energy_total),
    .energy_rate    (cell_out.energy_rate),
    .is_last        (cell_out.is_last)
  );

endmodule

// File: rtl/zcet_checker.sv
module zcet_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [zcet_pkg::ED_W-1:0]    energy_density,
  input  logic signed [zcet_pkg::ACC_W-1:0]   energy_total,
  input  logic signed [zcet_pkg::ACC_W-1:0]   energy_rate,
  input  logic                                is_last
);
  import zcet_pkg::*;

  // One cell at a time: no new transfer right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an input transfer");

  // Totals only on the last cell of a chunk.
  a_totals_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_last) |-> (energy_total == '0 && energy_rate == '0))
    else $error("totals nonzero on a cell that is not last");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(energy_density) && $stable(energy_total) &&
       $stable(energy_rate) && $stable(is_last)))
    else $error("stalled result changed");

  // After reset: no result pending, ready for a cell.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("bad state after reset");

endmodule

bind zeeman_cell_energy_torque_unit zcet_checker u_zcet_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (cell_in.valid),
  .in_ready       (cell_in.ready),
  .out_valid      (cell_out.valid),
  .out_ready      (cell_out.ready),
  .energy_density (cell_out.energy_density),
  .energy_total   (cell_out.energy_total),
  .energy_rate    (cell_out.energy_rate),
  .is_last        (cell_out.is_last)
);
